// File: rtl/core/rhsv_pkg.sv
// Shared constants, types and the divider step for the RGB to HSV converter.
package rhsv_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int FRACTION_BITS = 16;
    // 6 * delta stays below 2^(CHANNEL_BITS + 3)
    localparam int DIV_BITS      = CHANNEL_BITS + 3;
    localparam int DIV_STAGES    = FRACTION_BITS;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    // classified pixel, handed from front to back
    typedef struct packed {
        logic [DIV_BITS-1:0]     hue_num;
        logic [DIV_BITS-1:0]     hue_div;
        logic [CHANNEL_BITS-1:0] sat_num;
        logic [CHANNEL_BITS-1:0] sat_div;
        logic [CHANNEL_BITS-1:0] value;
        logic                    hue_zero;
        logic                    sat_zero;
        logic                    sat_full;
    } t_job;

    // one divider pipeline stage
    typedef struct packed {
        logic [DIV_BITS-1:0]      hue_rem;
        logic [DIV_BITS-1:0]      hue_div;
        logic [FRACTION_BITS-1:0] hue_quot;
        logic [CHANNEL_BITS-1:0]  sat_rem;
        logic [CHANNEL_BITS-1:0]  sat_div;
        logic [FRACTION_BITS-1:0] sat_quot;
        logic [CHANNEL_BITS-1:0]  value;
        logic                     hue_zero;
        logic                     sat_zero;
        logic                     sat_full;
    } t_div_stage;

    function automatic t_div_stage div_load(input t_job job);
        t_div_stage s;
        s.hue_rem  = job.hue_num;
        s.hue_div  = job.hue_div;
        s.hue_quot = '0;
        s.sat_rem  = job.sat_num;
        s.sat_div  = job.sat_div;
        s.sat_quot = '0;
        s.value    = job.value;
        s.hue_zero = job.hue_zero;
        s.sat_zero = job.sat_zero;
        s.sat_full = job.sat_full;
        return s;
    endfunction

    // one restoring division step for both quotients
    function automatic t_div_stage div_step(input t_div_stage s);
        t_div_stage            r;
        logic [DIV_BITS:0]     hue_sh;
        logic [CHANNEL_BITS:0] sat_sh;
        logic                  hue_bit;
        logic                  sat_bit;
        r       = s;
        hue_sh  = {s.hue_rem, 1'b0};
        sat_sh  = {s.sat_rem, 1'b0};
        hue_bit = (hue_sh >= {1'b0, s.hue_div});
        sat_bit = (sat_sh >= {1'b0, s.sat_div});
        r.hue_rem  = hue_bit ? DIV_BITS'(hue_sh - {1'b0, s.hue_div}) : DIV_BITS'(hue_sh);
        r.sat_rem  = sat_bit ? CHANNEL_BITS'(sat_sh - {1'b0, s.sat_div})
                             : CHANNEL_BITS'(sat_sh);
        r.hue_quot = {s.hue_quot[FRACTION_BITS-2:0], hue_bit};
        r.sat_quot = {s.sat_quot[FRACTION_BITS-2:0], sat_bit};
        return r;
    endfunction

endpackage

// File: rtl/core/rhsv_front.sv
// Front stage: max/min/delta, hue sector and divider operands, registered.
module rhsv_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [rhsv_pkg::CHANNEL_BITS-1:0]   i_red,
    input  logic [rhsv_pkg::CHANNEL_BITS-1:0]   i_green,
    input  logic [rhsv_pkg::CHANNEL_BITS-1:0]   i_blue,
    output logic                                o_valid,
    input  logic                                i_ready,
    output rhsv_pkg::t_job                      o_job
);
    import rhsv_pkg::*;

    logic                      r_valid;
    logic                      n_valid;
    t_job                      r_job;
    t_job                      n_job;
    logic [CHANNEL_BITS-1:0]   mx;
    logic [CHANNEL_BITS-1:0]   mn;
    logic [CHANNEL_BITS-1:0]   delta;
    logic signed [DIV_BITS:0]  num;
    logic [DIV_BITS-1:0]       turn;
    logic                      take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        mx = (i_red >= i_green) ? i_red : i_green;
        mx = (mx >= i_blue) ? mx : i_blue;
        mn = (i_red <= i_green) ? i_red : i_green;
        mn = (mn <= i_blue) ? mn : i_blue;
        delta = mx - mn;
        turn  = DIV_BITS'({delta, 2'b00}) + DIV_BITS'({delta, 1'b0});
        // sector by priority: red, then green, then blue
        priority if (i_red == mx) begin
            num = $signed({1'b0, DIV_BITS'(i_green)}) - $signed({1'b0, DIV_BITS'(i_blue)});
        end else if (i_green == mx) begin
            num = $signed({1'b0, DIV_BITS'({delta, 1'b0})})
                + $signed({1'b0, DIV_BITS'(i_blue)}) - $signed({1'b0, DIV_BITS'(i_red)});
        end else begin
            num = $signed({1'b0, DIV_BITS'({delta, 2'b00})})
                + $signed({1'b0, DIV_BITS'(i_red)}) - $signed({1'b0, DIV_BITS'(i_green)});
        end
        if (num < 0) begin
            num = num + $signed({1'b0, turn});
        end
        n_job.hue_num  = DIV_BITS'(num);
        n_job.hue_div  = turn;
        n_job.sat_num  = delta;
        n_job.sat_div  = mx;
        n_job.value    = mx;
        n_job.hue_zero = (delta == '0);
        n_job.sat_zero = (mx == '0);
        n_job.sat_full = (delta == mx);
    end

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= n_job;
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;

endmodule

// File: rtl/core/rhsv_queue.sv
// Short FIFO between the classify front and the divider back.
module rhsv_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rhsv_pkg::t_job  i_job,
    output logic            o_valid,
    input  logic            i_ready,
    output rhsv_pkg::t_job  o_job
);
    import rhsv_pkg::*;

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] n_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QPTR_BITS-1:0] n_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QCNT_BITS-1:0] n_count;
    logic                 push;
    logic                 pop;

    function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
        return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : QPTR_BITS'(p + 1'b1);
    endfunction

    assign o_ready = (r_count != QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = QCNT_BITS'(r_count + 1'b1);
        end else if (pop && !push) begin
            n_count = QCNT_BITS'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: rtl/core/rhsv_back.sv
// Back end: pipelined restoring dividers for hue and saturation, one bit per stage.
module rhsv_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  rhsv_pkg::t_job                       i_job,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [rhsv_pkg::FRACTION_BITS-1:0]   o_hue,
    output logic [rhsv_pkg::FRACTION_BITS-1:0]   o_saturation,
    output logic [rhsv_pkg::CHANNEL_BITS-1:0]    o_value
);
    import rhsv_pkg::*;

    logic       r_vld [DIV_STAGES];
    logic       n_vld [DIV_STAGES];
    t_div_stage r_stg [DIV_STAGES];
    t_div_stage n_stg [DIV_STAGES];
    logic       en    [DIV_STAGES];
    t_div_stage last;

    // a stage moves when it is empty or the next one moves (bubbles collapse)
    always_comb begin
        en[DIV_STAGES-1] = !r_vld[DIV_STAGES-1] || i_ready;
        for (int k = DIV_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_comb begin
        n_stg[0] = div_step(div_load(i_job));
        n_vld[0] = en[0] ? i_valid : r_vld[0];
        for (int k = 1; k < DIV_STAGES; k++) begin
            n_stg[k] = div_step(r_stg[k-1]);
            n_vld[k] = en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_vld[k] <= n_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (en[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_ready = en[0];
    assign last    = r_stg[DIV_STAGES-1];
    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_value = last.value;
    assign o_hue   = last.hue_zero ? '0 : last.hue_quot;

    always_comb begin
        priority if (last.sat_zero) begin
            o_saturation = '0;
        end else if (last.sat_full) begin
            o_saturation = '1;
        end else begin
            o_saturation = last.sat_quot;
        end
    end

endmodule

// File: rtl/core/rgb_to_hsv_converter.sv
// Path: an accepted pixel transaction goes through the classify register, one queue
// slot and the 16 divider stages before its result is presented.
// Throughput: one pixel per cycle while the output is not stalled, set by the 16-stage
// pipelined dividers for hue and saturation, one quotient bit per stage.
// Reset: i_rst_n is synchronous, active low; it empties the front register, the queue
// and the divider pipeline, so o_valid is low after reset. Payload is not cleared.
module rgb_to_hsv_converter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // pixel transaction in
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [rhsv_pkg::CHANNEL_BITS-1:0]    i_red,
    input  logic [rhsv_pkg::CHANNEL_BITS-1:0]    i_green,
    input  logic [rhsv_pkg::CHANNEL_BITS-1:0]    i_blue,
    // HSV transaction out
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [rhsv_pkg::FRACTION_BITS-1:0]   o_hue,
    output logic [rhsv_pkg::FRACTION_BITS-1:0]   o_saturation,
    output logic [rhsv_pkg::CHANNEL_BITS-1:0]    o_value
);
    import rhsv_pkg::*;

    // front -> queue
    logic fq_valid;
    logic fq_ready;
    t_job fq_job;
    // queue -> back
    logic qb_valid;
    logic qb_ready;
    t_job qb_job;

    // Front: finds max/min/delta, picks the hue sector (red wins ties, then
    // green), wraps a negative hue numerator by one turn (6*delta) and flags
    // the grey, black and fully saturated cases.
    rhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (fq_valid),
        .i_ready (fq_ready),
        .o_job   (fq_job)
    );

    // Short queue so the front keeps taking pixels while the back stalls, until it is full.
    rhsv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_job   (fq_job),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_job   (qb_job)
    );

    // Back: hue = floor(n * 2^16 / (6*delta)) and
    // saturation = floor(delta * 2^16 / max), both by restoring division,
    // then the special-case overrides on the last stage.
    rhsv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (qb_valid),
        .o_ready      (qb_ready),
        .i_job        (qb_job),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_value      (o_value)
    );

endmodule

// File: rtl/core/rhsv_checker.sv
// Port-level checker for the RGB to HSV converter, bound to the top level.
module rhsv_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 o_ready,
    input  logic [rhsv_pkg::CHANNEL_BITS-1:0]    i_red,
    input  logic [rhsv_pkg::CHANNEL_BITS-1:0]    i_green,
    input  logic [rhsv_pkg::CHANNEL_BITS-1:0]    i_blue,
    input  logic                                 o_valid,
    input  logic                                 i_ready,
    input  logic [rhsv_pkg::FRACTION_BITS-1:0]   o_hue,
    input  logic [rhsv_pkg::FRACTION_BITS-1:0]   o_saturation,
    input  logic [rhsv_pkg::CHANNEL_BITS-1:0]    o_value
);
    import rhsv_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hue) && $stable(o_saturation)
            && $stable(o_value))
        else $error("stalled result changed");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // black pixel: no saturation, no hue
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_value == '0) |-> (o_saturation == '0) && (o_hue == '0))
        else $error("black pixel with nonzero hue or saturation");

    // zero saturation means grey, so hue is zero
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_saturation == '0) |-> (o_hue == '0))
        else $error("grey pixel with nonzero hue");

endmodule

bind rgb_to_hsv_converter rhsv_checker u_rhsv_checker (.*);

// File: tb/sv/hsv_checker.sv
// Checker for the RGB to HSV converter: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module hsv_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_pix_valid,
    input  logic                                i_pix_ready,
    input  logic [rhsv_pkg::CHANNEL_BITS-1:0]   i_red,
    input  logic [rhsv_pkg::CHANNEL_BITS-1:0]   i_green,
    input  logic [rhsv_pkg::CHANNEL_BITS-1:0]   i_blue,
    input  logic                                i_hsv_valid,
    input  logic                                i_hsv_ready,
    input  logic [rhsv_pkg::FRACTION_BITS-1:0]  i_hue,
    input  logic [rhsv_pkg::FRACTION_BITS-1:0]  i_saturation,
    input  logic [rhsv_pkg::CHANNEL_BITS-1:0]   i_value,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import rhsv_pkg::*;

    typedef struct packed {
        logic [FRACTION_BITS-1:0] hue;
        logic [FRACTION_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0]  value;
    } t_hsv;

    localparam int FRAC_FULL = (1 << FRACTION_BITS) - 1;

    t_hsv hsv_due[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // exact integer HSV of one pixel; ties pick red, then green, then blue
    function automatic t_hsv hsv_of_pixel(input logic [CHANNEL_BITS-1:0] r,
                                          input logic [CHANNEL_BITS-1:0] g,
                                          input logic [CHANNEL_BITS-1:0] b);
        int   rr, gg, bb, mx, mn, delta, n, q;
        t_hsv h;
        rr = int'(r);
        gg = int'(g);
        bb = int'(b);
        mx = (rr > gg) ? rr : gg;
        mx = (mx > bb) ? mx : bb;
        mn = (rr < gg) ? rr : gg;
        mn = (mn < bb) ? mn : bb;
        delta = mx - mn;
        h.value = CHANNEL_BITS'(mx);
        if (delta == 0) begin
            h.hue = '0;
        end else begin
            if (rr == mx)      n = gg - bb;
            else if (gg == mx) n = 2 * delta + bb - rr;
            else               n = 4 * delta + rr - gg;
            if (n < 0) n += 6 * delta;
            h.hue = FRACTION_BITS'((n << FRACTION_BITS) / (6 * delta));
        end
        if (mx == 0) begin
            h.saturation = '0;
        end else begin
            q = (delta << FRACTION_BITS) / mx;
            h.saturation = FRACTION_BITS'((q > FRAC_FULL) ? FRAC_FULL : q);
        end
        return h;
    endfunction

    always @(posedge i_clk) begin
        t_hsv want;
        if (i_rst_n) begin
            if (i_pix_valid && i_pix_ready)
                hsv_due.push_back(hsv_of_pixel(i_red, i_green, i_blue));
            if (i_hsv_valid && i_hsv_ready) begin
                if (hsv_due.size() == 0) begin
                    $error("unexpected HSV transaction: hue %0d, saturation %0d, value %0d",
                           i_hue, i_saturation, i_value);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = hsv_due.pop_front();
                    if (i_hue !== want.hue)
                        $error("hue mismatch: expected %0d, actual %0d", want.hue, i_hue);
                    if (i_saturation !== want.saturation)
                        $error("saturation mismatch: expected %0d, actual %0d",
                               want.saturation, i_saturation);
                    if (i_value !== want.value)
                        $error("value mismatch: expected %0d, actual %0d", want.value, i_value);
                    if (i_hue !== want.hue || i_saturation !== want.saturation ||
                        i_value !== want.value)
                        o_fail_count <= o_fail_count + 1;
                end
            end
            o_pending <= hsv_due.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
// Top of the RGB to HSV converter testbench: clock, reset, pixel stimulus and verdict.
`timescale 1ns / 100ps

module tb;
    import rhsv_pkg::*;

    // Slowest correct run: ~1925 pixels, the sender idling ~18% of cycles and the output
    // stalled ~18% of the time, plus the pipeline latency. The limit is far above that.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1900;
    localparam int DRAIN_CYCLES = 40;       // comfortably above the pipeline latency
    localparam int IDLE_PCT     = 18;

    localparam logic [CHANNEL_BITS-1:0] CH_MAX = '1;

    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [CHANNEL_BITS-1:0]  i_red   = '0;
    logic [CHANNEL_BITS-1:0]  i_green = '0;
    logic [CHANNEL_BITS-1:0]  i_blue  = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [FRACTION_BITS-1:0] o_hue;
    logic [FRACTION_BITS-1:0] o_saturation;
    logic [CHANNEL_BITS-1:0]  o_value;

    int fail_count;
    int hsv_pending;
    int cycle_count = 0;
    // set during a long stretch in which neither side idles
    logic steady = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rgb_to_hsv_converter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_value      (o_value)
    );

    hsv_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (i_valid),
        .i_pix_ready  (o_ready),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_hsv_valid  (o_valid),
        .i_hsv_ready  (i_ready),
        .i_hue        (o_hue),
        .i_saturation (o_saturation),
        .i_value      (o_value),
        .o_fail_count (fail_count),
        .o_pending    (hsv_pending)
    );

    // Watchdog: a hung handshake or a result that never shows up ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Output side backpressure: stall about IDLE_PCT percent of cycles, never while steady.
    always @(posedge i_clk) begin
        i_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Drive one pixel transaction. Called at a rising edge; returns at the edge where the
    // pixel was accepted, with i_valid still high so a back-to-back pixel keeps it up.
    // Each cycle before the pixel goes out idles with IDLE_PCT percent odds, except while steady.
    task automatic send_pixel(input logic [CHANNEL_BITS-1:0] r,
                              input logic [CHANNEL_BITS-1:0] g,
                              input logic [CHANNEL_BITS-1:0] b);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Random pixel, biased toward greys, ties, zero minimum and tiny values
    // so every hue sector and special case keeps coming up.
    task automatic send_random_pixel();
        logic [CHANNEL_BITS-1:0] r, g, b, top;
        int mode;
        r    = CHANNEL_BITS'($urandom);
        g    = CHANNEL_BITS'($urandom);
        b    = CHANNEL_BITS'($urandom);
        top  = CHANNEL_BITS'($urandom);
        mode = $urandom_range(9);
        case (mode)
            0: begin           // grey: hue 0
                g = r;
                b = r;
            end
            1: begin           // two channels tie at the max
                case ($urandom_range(2))
                    0: begin
                        r = top;
                        g = top;
                        b = CHANNEL_BITS'(int'(b) % (int'(top) + 1));
                    end
                    1: begin
                        g = top;
                        b = top;
                        r = CHANNEL_BITS'(int'(r) % (int'(top) + 1));
                    end
                    default: begin
                        r = top;
                        b = top;
                        g = CHANNEL_BITS'(int'(g) % (int'(top) + 1));
                    end
                endcase
            end
            2: begin           // one channel at zero: saturation held at full unless black
                case ($urandom_range(2))
                    0: r = '0;
                    1: g = '0;
                    default: b = '0;
                endcase
            end
            3: begin           // near black
                r = CHANNEL_BITS'($urandom_range(3));
                g = CHANNEL_BITS'($urandom_range(3));
                b = CHANNEL_BITS'($urandom_range(3));
            end
            default: ;
        endcase
        send_pixel(r, g, b);
    endtask

    initial begin
        // synchronous reset, held asserted before the first pixel
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels
        send_pixel('0, '0, '0);                 // black: saturation 0, hue 0
        send_pixel(CH_MAX, CH_MAX, CH_MAX);     // white: grey at full scale
        send_pixel(8'd128, 8'd128, 8'd128);     // mid grey
        send_pixel(8'd1, 8'd1, 8'd1);           // smallest nonzero grey
        send_pixel(CH_MAX, '0, '0);             // pure red
        send_pixel('0, CH_MAX, '0);             // pure green
        send_pixel('0, '0, CH_MAX);             // pure blue
        send_pixel(CH_MAX, CH_MAX, '0);         // red/green tie: red sector wins
        send_pixel('0, CH_MAX, CH_MAX);         // green/blue tie: green sector wins
        send_pixel(CH_MAX, '0, CH_MAX);         // red/blue tie: red sector, hue wraps
        send_pixel(CH_MAX, '0, 8'd10);          // red max, negative sector offset
        send_pixel(CH_MAX, 8'd10, '0);          // red max, small positive hue
        send_pixel(8'd20, CH_MAX, 8'd200);      // green max, blue above red
        send_pixel(8'd200, CH_MAX, 8'd20);      // green max, red above blue
        send_pixel(8'd30, 8'd90, CH_MAX);       // blue max, green above red
        send_pixel(8'd90, 8'd30, CH_MAX);       // blue max, red above green
        send_pixel(8'd1, '0, '0);               // smallest nonzero max, full saturation
        send_pixel('0, 8'd1, '0);
        send_pixel('0, '0, 8'd1);
        send_pixel(CH_MAX, 8'd254, 8'd254);     // delta 1 at full scale
        send_pixel(8'd254, CH_MAX, 8'd254);
        send_pixel(8'd254, 8'd254, CH_MAX);
        send_pixel(8'd2, 8'd1, 8'd1);           // saturation exactly one half
        send_pixel(8'hAA, 8'h55, 8'h0F);        // alternating bit and nibble patterns
        send_pixel(8'h55, 8'hAA, 8'hF0);

        // Random pixels, with a long burst where neither side ever idles
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            steady <= (k >= 800 && k < 1200);
            send_random_pixel();
        end
        steady  <= 1'b0;
        i_valid <= 1'b0;

        // drain: wait for every expected result, then a little more for strays
        while (hsv_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: rgb_to_hsv_converter.f
rtl/core/rhsv_pkg.sv
rtl/core/rhsv_front.sv
rtl/core/rhsv_queue.sv
rtl/core/rhsv_back.sv
rtl/core/rgb_to_hsv_converter.sv
rtl/core/rhsv_checker.sv
tb/sv/hsv_checker.sv
tb/sv/tb.sv
